FILE: rtl/core/tce_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and state encoding for the text console engine.
package tce_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int TAB_SPACING    = 4;

	localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int ROW_W      = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int COL_W      = $clog2(SCREEN_COLUMNS);
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int TAB_W      = (TAB_SPACING > 1) ? $clog2(TAB_SPACING) : 1;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN  = 8'd13;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] RESET_ATTR = 8'h0F;

	localparam logic ACT_PUT  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_CLEAR,
		ST_READ,
		ST_RWAIT,
		ST_FINISH
	} tce_state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       wdata;
	} mem_req_t;

endpackage

FILE: rtl/core/tce_addr_unit.sv
`timescale 1ns / 1ps
// Shared address unit: row rotation by the scroll offset, then row times width plus column.
module tce_addr_unit (
	input  logic [tce_pkg::ROW_W-1:0]  row,
	input  logic [tce_pkg::ROW_W-1:0]  offset,
	input  logic [tce_pkg::COL_W-1:0]  col,
	output logic [tce_pkg::ADDR_W-1:0] addr
);
	import tce_pkg::*;

	logic [ROW_W:0]   sum;
	logic [ROW_W-1:0] prow;

	always_comb begin
		sum = {1'b0, row} + {1'b0, offset};
		// wrap once: both operands are below the row count, except for an out-of-range query whose read data is discarded
		if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
			prow = ROW_W'(sum - (ROW_W+1)'(SCREEN_ROWS));
		end else begin
			prow = ROW_W'(sum);
		end
		addr = ADDR_W'(prow) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
	end

endmodule

FILE: rtl/core/tce_screen_mem.sv
`timescale 1ns / 1ps
// Single-port screen cell memory with registered read data.
module tce_screen_mem (
	input  logic              clk,
	input  tce_pkg::mem_req_t req,
	output logic [15:0]       rdata
);
	import tce_pkg::*;

	logic [15:0] mem [CELL_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

endmodule

FILE: rtl/core/tce_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: cursor, scroll offset, cell writes, row clears, reads and the result register.
module tce_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 attr,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [7:0]                 glyph_byte,
	input  logic [4:0]                 query_row,
	input  logic [6:0]                 query_column,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [4:0]                 shown_row,
	output logic [6:0]                 shown_column,
	output logic [10:0]                cursor_linear,
	output logic [7:0]                 cell_glyph,
	output logic [7:0]                 cell_colour,
	output tce_pkg::mem_req_t          mem_req,
	input  logic [15:0]                mem_rdata
);
	import tce_pkg::*;

	tce_state_t        state_q, state_nx;
	logic [ROW_W-1:0]  top_q, top_inc;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [TAB_W-1:0]  tab_ph_q, tab_ph_inc;
	logic              is_tab_q;
	logic [7:0]        glyph_q;
	logic [ROW_W-1:0]  qrow_q;
	logic [COL_W-1:0]  qcol_q;
	logic              qok_q;
	logic [ROW_W-1:0]  clr_row_q;
	logic [COL_W-1:0]  clr_col_q;
	logic [7:0]        cg_q, cc_q;
	logic              out_valid_q;
	logic [4:0]        shown_row_q;
	logic [6:0]        shown_column_q;
	logic [10:0]       cursor_linear_q;
	logic [7:0]        cell_glyph_q;
	logic [7:0]        cell_colour_q;

	logic              accept;
	logic              last_row;
	logic              col_last;
	logic              clr_col_last;
	logic              out_free;
	logic [ROW_W-1:0]  u_row, u_off;
	logic [COL_W-1:0]  u_col;
	logic [ADDR_W-1:0] u_addr;

	tce_addr_unit u_addr_unit (
		.row    (u_row),
		.offset (u_off),
		.col    (u_col),
		.addr   (u_addr)
	);

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign out_free     = !out_valid_q || out_ready;
	assign last_row     = ((ROW_W+1)'(cur_row_q) + (ROW_W+1)'(1)) == (ROW_W+1)'(SCREEN_ROWS);
	assign col_last     = ((COL_W+1)'(cur_col_q) + (COL_W+1)'(1)) == (COL_W+1)'(SCREEN_COLUMNS);
	assign clr_col_last = ((COL_W+1)'(clr_col_q) + (COL_W+1)'(1)) == (COL_W+1)'(SCREEN_COLUMNS);
	assign top_inc      = (32'(top_q) == SCREEN_ROWS - 1) ? '0 : top_q + ROW_W'(1);
	assign tab_ph_inc   = (32'(tab_ph_q) == TAB_SPACING - 1) ? '0 : tab_ph_q + TAB_W'(1);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_INIT: begin
				if (clr_col_last && (32'(clr_row_q) == SCREEN_ROWS - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (action == ACT_READ) begin
						state_nx = ST_READ;
					end else if (glyph_byte == CH_NEWLINE) begin
						state_nx = last_row ? ST_CLEAR : ST_FINISH;
					end else if (glyph_byte == CH_RETURN) begin
						state_nx = ST_FINISH;
					end else begin
						state_nx = ST_PUT;
					end
				end
			end
			ST_PUT: begin
				if (col_last) begin
					state_nx = last_row ? ST_CLEAR : ST_FINISH;
				end else if (!(is_tab_q && (tab_ph_inc != '0))) begin
					state_nx = ST_FINISH;
				end
			end
			ST_CLEAR: begin
				if (clr_col_last) begin
					state_nx = ST_FINISH;
				end
			end
			ST_READ:   state_nx = ST_RWAIT;
			ST_RWAIT:  state_nx = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default:   state_nx = ST_INIT;
		endcase
	end

	// shared unit operands and memory request
	always_comb begin
		u_row   = cur_row_q;
		u_off   = '0;
		u_col   = cur_col_q;
		mem_req = '{we: 1'b0, addr: u_addr, wdata: {attr, CH_SPACE}};
		case (state_q)
			ST_INIT: begin
				u_row   = clr_row_q;
				u_col   = clr_col_q;
				mem_req = '{we: 1'b1, addr: u_addr, wdata: {RESET_ATTR, CH_SPACE}};
			end
			ST_PUT: begin
				u_off   = top_q;
				mem_req = '{we: 1'b1, addr: u_addr, wdata: {attr, glyph_q}};
			end
			ST_CLEAR: begin
				u_row   = clr_row_q;
				u_col   = clr_col_q;
				mem_req = '{we: 1'b1, addr: u_addr, wdata: {attr, CH_SPACE}};
			end
			ST_READ: begin
				u_row = qrow_q;
				u_off = top_q;
				u_col = qcol_q;
			end
			default: begin
				u_row = cur_row_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			top_q       <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			tab_ph_q    <= '0;
			clr_row_q   <= '0;
			clr_col_q   <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_INIT: begin
					if (clr_col_last) begin
						clr_col_q <= '0;
						clr_row_q <= clr_row_q + ROW_W'(1);
					end else begin
						clr_col_q <= clr_col_q + COL_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept && (action == ACT_PUT)) begin
						if (glyph_byte == CH_NEWLINE) begin
							cur_col_q <= '0;
							tab_ph_q  <= '0;
							if (last_row) begin
								// new bottom row lands on the old top row
								top_q     <= top_inc;
								clr_row_q <= top_q;
								clr_col_q <= '0;
							end else begin
								cur_row_q <= cur_row_q + ROW_W'(1);
							end
						end else if (glyph_byte == CH_RETURN) begin
							cur_col_q <= '0;
							tab_ph_q  <= '0;
						end
					end
				end
				ST_PUT: begin
					if (col_last) begin
						cur_col_q <= '0;
						tab_ph_q  <= '0;
						if (last_row) begin
							top_q     <= top_inc;
							clr_row_q <= top_q;
							clr_col_q <= '0;
						end else begin
							cur_row_q <= cur_row_q + ROW_W'(1);
						end
					end else begin
						cur_col_q <= cur_col_q + COL_W'(1);
						tab_ph_q  <= tab_ph_inc;
					end
				end
				ST_CLEAR: begin
					clr_col_q <= clr_col_q + COL_W'(1);
				end
				default: begin
					// hold cursor and scroll state
				end
			endcase
		end
	end

	// result valid: set when a result is loaded, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			is_tab_q <= (glyph_byte == CH_TAB);
			glyph_q  <= (glyph_byte == CH_TAB) ? CH_SPACE : glyph_byte;
			qrow_q   <= ROW_W'(query_row);
			qcol_q   <= COL_W'(query_column);
			qok_q    <= (32'(query_row) < SCREEN_ROWS) && (32'(query_column) < SCREEN_COLUMNS);
			cg_q     <= '0;
			cc_q     <= '0;
		end
		if (state_q == ST_RWAIT && qok_q) begin
			cg_q <= mem_rdata[7:0];
			cc_q <= mem_rdata[15:8];
		end
		if (state_q == ST_FINISH && out_free) begin
			shown_row_q     <= 5'(cur_row_q);
			shown_column_q  <= 7'(cur_col_q);
			cursor_linear_q <= 11'(u_addr);
			cell_glyph_q    <= cg_q;
			cell_colour_q   <= cc_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign shown_row     = shown_row_q;
	assign shown_column  = shown_column_q;
	assign cursor_linear = cursor_linear_q;
	assign cell_glyph    = cell_glyph_q;
	assign cell_colour   = cell_colour_q;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_col_q) < SCREEN_COLUMNS)
		else $error("cursor column out of range");

	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_q) < SCREEN_ROWS)
		else $error("scroll offset out of range");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_READ || state_q == ST_FINISH) |-> !mem_req.we)
		else $error("cell write outside a write state");

	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && !out_ready) |=> state_q == ST_FINISH)
		else $error("result dropped while output register full");

	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR && state_nx == ST_CLEAR) |=> clr_col_q == '0)
		else $error("row clear did not start at column zero");

endmodule

FILE: rtl/core/text_console_engine.sv
`timescale 1ns / 1ps
// Text console engine top level: attribute register, sequencer and screen memory.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_ready | action, glyph_byte, query_row, query_column
//  out     | output    | out_valid/out_ready | shown_row, shown_column, cursor_linear,
//          |           |                     | cell_glyph, cell_colour
//  cfg     | input     | cfg_wr_en           | cfg_wr_data (text attribute)
//
// One item is worked at a time through the single-port screen memory, one cell per cycle.
// Return or newline writes no cell; a plain byte writes one; a tab writes spaces up to the
// next tab stop (up to TAB_SPACING cells); a read waits for the registered data; a scroll
// clears the new bottom row (80 cells). Reset clears all 2000 cells with in_ready low.
// A result waits in the output register while the next item is accepted and worked;
// the block stalls only when a second result is ready before the first is taken.
module text_console_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  glyph_byte,
	input  logic [4:0]  query_row,
	input  logic [6:0]  query_column,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  shown_row,
	output logic [6:0]  shown_column,
	output logic [10:0] cursor_linear,
	output logic [7:0]  cell_glyph,
	output logic [7:0]  cell_colour
);
	import tce_pkg::*;

	logic [7:0]  attr_q;
	mem_req_t    mem_req;
	logic [15:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	tce_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.attr          (attr_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.glyph_byte    (glyph_byte),
		.query_row     (query_row),
		.query_column  (query_column),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.shown_row     (shown_row),
		.shown_column  (shown_column),
		.cursor_linear (cursor_linear),
		.cell_glyph    (cell_glyph),
		.cell_colour   (cell_colour),
		.mem_req       (mem_req),
		.mem_rdata     (mem_rdata)
	);

	tce_screen_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule
